>>> src/hpq_pkg.sv
// shared types, constants and command/status records for the max-heap priority queue
`default_nettype none
package hpq_pkg;

  // heap size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = IDX_W + 2;

  // fixed item field widths
  localparam int OP_W     = 2;
  localparam int PRIO_W   = 16;
  localparam int ID_W     = 8;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 3;
  localparam int OCNT_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_FIND     = 2'd2,
    OP_INCREASE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOTLARGER = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [ID_W-1:0]          id;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic err;
    logic at_root;
    logic up_swap;
    logic dn_swap;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> src/hpq_if.sv
// valid/ready channel interfaces for request items and result items
`default_nettype none
interface hpq_in_if;
  logic                          valid;
  logic                          ready;
  logic [hpq_pkg::OP_W-1:0]      op;
  logic signed [hpq_pkg::PRIO_W-1:0] priority_req;
  logic [hpq_pkg::ID_W-1:0]      entry_id;
  logic [hpq_pkg::POS_W-1:0]     position;

  modport source (output valid, output op, output priority_req, output entry_id,
                  output position, input ready);
  modport sink (input valid, input op, input priority_req, input entry_id,
                input position, output ready);
endinterface

interface hpq_out_if;
  logic                              valid;
  logic                              ready;
  logic [hpq_pkg::STAT_W-1:0]        status;
  logic signed [hpq_pkg::PRIO_W-1:0] out_priority;
  logic [hpq_pkg::ID_W-1:0]          out_id;
  logic [hpq_pkg::OCNT_W-1:0]        count;

  modport source (output valid, output status, output out_priority, output out_id,
                  output count, input ready);
  modport sink (input valid, input status, input out_priority, input out_id,
                input count, output ready);
endinterface
`default_nettype wire

>>> src/hpq_ctrl.sv
// controller state machine sequencing request decode, sift up and sift down
`default_nettype none
module hpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hpq_pkg::sts_t sts,
  output hpq_pkg::cmd_t      cmd
);
  import hpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_UP_RD  = 7'b0000100,
    S_UP_CMP = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.err || sts.op == OP_FIND) begin
          state_nxt = S_RESP;
        end else if (sts.op inside {OP_INSERT, OP_INCREASE}) begin
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        cmd.up_rd = 1'b1;
        state_nxt = sts.at_root ? S_RESP : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_nxt  = sts.up_swap ? S_UP_RD : S_RESP;
      end
      S_DN_RD: begin
        cmd.dn_rd = 1'b1;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_nxt  = sts.dn_swap ? S_DN_RD : S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/hpq_dp.sv
// datapath: heap memory, moving entry, index, count and result registers
`default_nettype none
module hpq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hpq_pkg::cmd_t                 cmd,
  output hpq_pkg::sts_t                      sts,
  input  wire logic [hpq_pkg::OP_W-1:0]      in_op,
  input  wire logic signed [hpq_pkg::PRIO_W-1:0] in_priority_req,
  input  wire logic [hpq_pkg::ID_W-1:0]      in_entry_id,
  input  wire logic [hpq_pkg::POS_W-1:0]     in_position,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [hpq_pkg::STAT_W-1:0]         out_status,
  output logic signed [hpq_pkg::PRIO_W-1:0]  out_priority,
  output logic [hpq_pkg::ID_W-1:0]           out_id,
  output logic [hpq_pkg::OCNT_W-1:0]         out_count
);
  import hpq_pkg::*;

  // heap storage, one write and two registered read ports
  entry_t mem [CAPACITY];
  entry_t rd_a_r, rd_b_r;
  logic [IDX_W-1:0] ra, rb, wa;
  entry_t wd;
  logic we;

  // request, working and result registers
  op_t                      op_r;
  logic signed [PRIO_W-1:0] key_r;
  logic [ID_W-1:0]          id_r;
  logic [POS_W-1:0]         pos_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         idx_r;
  entry_t                   cur_r;
  status_t                  res_status_r;
  entry_t                   res_entry_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  entry_t                   out_entry_r;
  logic [OCNT_W-1:0]        out_count_r;

  status_t          err_code;
  logic [IDX_W-1:0] parent;
  logic [CH_W-1:0]  lch, rch;
  logic             l_win, r_win;
  logic signed [PRIO_W-1:0] big_prio;
  logic             returns_root;

  // neighbor indexes
  assign parent = (idx_r - IDX_W'(1)) >> 1;
  assign lch    = {1'b0, idx_r, 1'b1};
  assign rch    = lch + CH_W'(1);

  // sift down child selection, left first, right only if strictly larger
  assign l_win    = (lch < CH_W'(cnt_r)) && (rd_a_r.prio > cur_r.prio);
  assign big_prio = l_win ? rd_a_r.prio : cur_r.prio;
  assign r_win    = (rch < CH_W'(cnt_r)) && (rd_b_r.prio > big_prio);

  // request checks on the freshly read entries
  always_comb begin
    err_code = ST_OK;
    case (op_r)
      OP_INSERT:  if (cnt_r == CNT_W'(CAPACITY)) err_code = ST_FULL;
      OP_EXTRACT: if (cnt_r == '0) err_code = ST_EMPTY;
      OP_FIND:    if (cnt_r == '0) err_code = ST_EMPTY;
      OP_INCREASE: begin
        if ({1'b0, pos_r} >= (POS_W+1)'(cnt_r)) begin
          err_code = ST_RANGE;
        end else if (rd_a_r.prio >= key_r) begin
          err_code = ST_NOTLARGER;
        end
      end
      default: err_code = ST_OK;
    endcase
  end

  assign returns_root = (op_r == OP_EXTRACT) || (op_r == OP_FIND);

  // status toward the controller
  always_comb begin
    sts.op       = op_r;
    sts.err      = (err_code != ST_OK);
    sts.at_root  = (idx_r == '0);
    sts.up_swap  = (cur_r.prio > rd_a_r.prio);
    sts.dn_swap  = l_win || r_win;
    sts.out_free = !out_valid_r || out_ready;
  end

  // memory address and write selection
  always_comb begin
    ra = '0;
    rb = IDX_W'(cnt_r - CNT_W'(1));
    we = 1'b0;
    wa = idx_r;
    wd = cur_r;
    if (cmd.take) begin
      ra = (op_t'(in_op) == OP_INCREASE) ? IDX_W'(in_position) : '0;
    end else if (cmd.up_rd) begin
      ra = parent;
      we = sts.at_root;
    end else if (cmd.dn_rd) begin
      ra = lch[IDX_W-1:0];
      rb = rch[IDX_W-1:0];
    end
    if (cmd.up_cmp) begin
      we = 1'b1;
      wd = sts.up_swap ? rd_a_r : cur_r;
    end
    if (cmd.dn_cmp) begin
      we = 1'b1;
      wd = r_win ? rd_b_r : (l_win ? rd_a_r : cur_r);
    end
  end

  // heap memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // request capture, moving entry, index and result payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= op_t'(in_op);
      key_r <= in_priority_req;
      id_r  <= in_entry_id;
      pos_r <= in_position;
    end
    if (cmd.exec) begin
      res_status_r <= err_code;
      res_entry_r  <= (err_code == ST_OK && returns_root) ? rd_a_r : '0;
      if (err_code == ST_OK) begin
        case (op_r)
          OP_INSERT: begin
            cur_r <= '{prio: key_r, id: id_r};
            idx_r <= IDX_W'(cnt_r);
          end
          OP_EXTRACT: begin
            cur_r <= rd_b_r;
            idx_r <= '0;
          end
          OP_INCREASE: begin
            cur_r <= '{prio: key_r, id: rd_a_r.id};
            idx_r <= IDX_W'(pos_r);
          end
          default: begin
            cur_r <= cur_r;
          end
        endcase
      end
    end
    if (cmd.up_cmp && sts.up_swap) begin
      idx_r <= parent;
    end
    if (cmd.dn_cmp && sts.dn_swap) begin
      idx_r <= r_win ? rch[IDX_W-1:0] : lch[IDX_W-1:0];
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_count_r  <= OCNT_W'(cnt_r);
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec && err_code == ST_OK) begin
      if (op_r == OP_INSERT) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (op_r == OP_EXTRACT) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_priority = out_entry_r.prio;
  assign out_id       = out_entry_r.id;
  assign out_count    = out_count_r;

endmodule
`default_nettype wire

>>> src/binary_max_heap_priority_queue.sv
// Binary max-heap priority queue of up to 64 entries (16-bit signed priority, 8-bit id).
// Request items arrive on in_chan: op selects insert, extract max, find max or
// increase key. Each request gives exactly one result item on out_chan with a
// status code, the returned entry (zero unless extract or find succeeded) and
// the entry count after the request.
// One request is worked on at a time; in_chan.ready is high only while idle.
// For find and for refused requests the result is loaded into the output register
// in the response step that follows the exec step. Insert and increase run a parent
// read step and a compare/write step per parent compare, and a final read step
// writes the entry when it climbs to the root. Extract runs a child read step and
// a compare/write step per level until the moved entry stops sinking, and then the
// result is loaded. The next request is taken the cycle after the result is
// loaded.
// The result sits in an output register; a new request is accepted while it
// waits, but the following result is held back until out_chan.ready takes the
// previous one.
// Reset (rst_n low, synchronous) empties the heap and drops any pending result;
// the heap memory itself is not cleared, since only positions below the count
// are ever used.
`default_nettype none
module binary_max_heap_priority_queue (
  input wire logic clk,
  input wire logic rst_n,
  hpq_in_if.sink   in_chan,
  hpq_out_if.source out_chan
);
  import hpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // heap storage and arithmetic
  hpq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_chan.op),
    .in_priority_req (in_chan.priority_req),
    .in_entry_id     (in_chan.entry_id),
    .in_position     (in_chan.position),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_status      (out_chan.status),
    .out_priority    (out_chan.out_priority),
    .out_id          (out_chan.out_id),
    .out_count       (out_chan.count)
  );

  // one item in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request taken while another is in flight");

  // refused requests carry no entry
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != ST_OK |->
      out_chan.out_priority == '0 && out_chan.out_id == '0)
    else $error("nonzero entry on a refused request");

  // count stays within capacity and status within its codes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.count <= OCNT_W'(CAPACITY) &&
      out_chan.status <= ST_FULL)
    else $error("result count or status out of range");

endmodule
`default_nettype wire
